[rtl/bswrl_pkg.sv]
// ----------------------------------------------------------------------------
// bswrl_pkg: shared types and constants of the sliding window rate limiter
// Field widths, register map and the bucket store entry layout.
// ----------------------------------------------------------------------------
package bswrl_pkg;

  // store geometry
  localparam int unsigned MAX_BUCKETS = 2048;
  localparam int unsigned IDX_W       = $clog2(MAX_BUCKETS);
  localparam int unsigned CNT_W       = 12;
  localparam int unsigned EPOCH_W     = 4;

  // field widths
  localparam int unsigned BYTES_W = 32;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned TOTAL_W = 64;
  localparam int unsigned BSEC_W  = 20;
  localparam int unsigned LIMIT_W = 44;

  // divider step counter
  localparam int unsigned DIV_CNT_W = $clog2(TIME_W);

  // bytes per megabyte, walked bit by bit to build the threshold
  localparam int unsigned MB_W     = 20;
  localparam int unsigned MB_BIT_W = $clog2(MB_W);
  localparam logic [MB_W-1:0] MB_BYTES = MB_W'(1000000);

  // register reset values
  localparam logic [BSEC_W-1:0]  BSEC_RST  = BSEC_W'(1);
  localparam logic [CNT_W-1:0]   CNT_RST   = CNT_W'(600);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1);
  localparam logic [TOTAL_W-1:0] THR_RST   = TOTAL_W'(1000000);

  // configuration port: 64 bit data, registers at 8 byte strides
  localparam int unsigned PDATA_W    = 64;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned REG_IDX_LSB = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - REG_IDX_LSB;

  localparam logic [REG_IDX_W-1:0] REG_BUCKET_SECONDS = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_MB       = REG_IDX_W'(2);

  // one bucket store word: epoch tag and byte count
  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [TOTAL_W-1:0] bytes;
  } bkt_entry_t;

endpackage

[rtl/bucketed_sliding_window_rate_limit_core.sv]
// ----------------------------------------------------------------------------
// bucketed_sliding_window_rate_limit_core: sliding window byte counter
// Ring of time buckets in one synchronous memory, read-modify-write per word,
// running window total and a limit flag against limit_mb * 1000000.
// ----------------------------------------------------------------------------
// Sequence: accept, check, read and write of the head bucket, then the result;
//   an advance in time adds the divide and a read and a clear per bucket stepped over.
// One word in flight: no new word is taken until the last one has been emitted.
// Reset: asynchronous; a clearing pass over all 2048 words runs before the first word
//   and again on every 16th whole-window clear when the epoch tag wraps.
// A limit_mb write holds off input while the threshold is rebuilt.
module bucketed_sliding_window_rate_limit_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [31:0] transfer_bytes, [71:32] now_seconds
  input  logic [71:0]                      s_axis_tdata_i,
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [63:0] window_total
  output logic [63:0]                      m_axis_tdata_o,
  // [0] limit_hit
  output logic                             m_axis_tuser_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bswrl_pkg::PADDR_W-1:0]    paddr,
  input  logic [bswrl_pkg::PDATA_W-1:0]    pwdata,
  output logic [bswrl_pkg::PDATA_W-1:0]    prdata,
  output logic                             pready
);

  localparam int unsigned IDX_W   = bswrl_pkg::IDX_W;
  localparam int unsigned CNT_W   = bswrl_pkg::CNT_W;
  localparam int unsigned TIME_W  = bswrl_pkg::TIME_W;
  localparam int unsigned TOTAL_W = bswrl_pkg::TOTAL_W;
  localparam int unsigned BSEC_W  = bswrl_pkg::BSEC_W;
  localparam int unsigned EPOCH_W = bswrl_pkg::EPOCH_W;

  // state codes
  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_DIV    = 4'd3;
  localparam logic [3:0] S_DIVEND = 4'd4;
  localparam logic [3:0] S_SHRD   = 4'd5;
  localparam logic [3:0] S_SHWR   = 4'd6;
  localparam logic [3:0] S_ADDRD  = 4'd7;
  localparam logic [3:0] S_ADDWR  = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;
  localparam logic [3:0] S_SWEEP  = 4'd10;

  // configuration registers
  logic [BSEC_W-1:0]              bsec_q;
  logic [CNT_W-1:0]               cnt_q;
  logic [bswrl_pkg::LIMIT_W-1:0]  limit_q;
  logic [TOTAL_W-1:0]             thr_q;
  logic [TOTAL_W-1:0]             mcand_q;
  logic [bswrl_pkg::MB_BIT_W-1:0] thr_bit_q;
  logic                           thr_busy_q;
  logic                           cfg_wr;
  logic [bswrl_pkg::REG_IDX_W-1:0] cfg_idx;

  // control and datapath registers
  logic [3:0]         state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TIME_W-1:0]  last_q, last_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [IDX_W-1:0]   sweep_q, sweep_d;
  logic [CNT_W-1:0]   steps_q, steps_d;
  logic [bswrl_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [TIME_W-1:0]  quo_q, quo_d;
  logic [BSEC_W-1:0]  rem_q, rem_d;
  logic [bswrl_pkg::BYTES_W-1:0] bytes_q, bytes_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic               m_valid_q, m_valid_d;
  logic [TOTAL_W-1:0] out_total_q, out_total_d;
  logic               out_hit_q, out_hit_d;

  // memory port
  bswrl_pkg::bkt_entry_t mem_q [bswrl_pkg::MAX_BUCKETS];
  bswrl_pkg::bkt_entry_t rd_q;
  bswrl_pkg::bkt_entry_t mem_wdata;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [IDX_W-1:0]      mem_raddr;

  // helpers
  logic [CNT_W-1:0]   cnt_eff;
  logic [TOTAL_W-1:0] entry_val;
  logic [TIME_W-1:0]  last_eff;
  logic [BSEC_W:0]    trial;
  logic [CNT_W-1:0]   head_next;
  logic               in_acc;

  // configuration write and read
  assign pready  = 1'b1;
  assign cfg_idx = paddr[bswrl_pkg::PADDR_W-1:bswrl_pkg::REG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_idx)
      bswrl_pkg::REG_BUCKET_SECONDS: prdata = bswrl_pkg::PDATA_W'(bsec_q);
      bswrl_pkg::REG_BUCKET_COUNT:   prdata = bswrl_pkg::PDATA_W'(cnt_q);
      bswrl_pkg::REG_LIMIT_MB:       prdata = bswrl_pkg::PDATA_W'(limit_q);
      default:                       prdata = '0;
    endcase
  end

  // registers and threshold build: limit times one million by shift and add
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsec_q     <= bswrl_pkg::BSEC_RST;
      cnt_q      <= bswrl_pkg::CNT_RST;
      limit_q    <= bswrl_pkg::LIMIT_RST;
      thr_q      <= bswrl_pkg::THR_RST;
      mcand_q    <= '0;
      thr_bit_q  <= '0;
      thr_busy_q <= 1'b0;
    end else if (cfg_wr && cfg_idx == bswrl_pkg::REG_LIMIT_MB) begin
      limit_q    <= pwdata[bswrl_pkg::LIMIT_W-1:0];
      mcand_q    <= TOTAL_W'(pwdata[bswrl_pkg::LIMIT_W-1:0]);
      thr_q      <= '0;
      thr_bit_q  <= '0;
      thr_busy_q <= 1'b1;
    end else begin
      if (cfg_wr && cfg_idx == bswrl_pkg::REG_BUCKET_SECONDS) begin
        bsec_q <= pwdata[BSEC_W-1:0];
      end
      if (cfg_wr && cfg_idx == bswrl_pkg::REG_BUCKET_COUNT) begin
        cnt_q <= pwdata[CNT_W-1:0];
      end
      if (thr_busy_q) begin
        if (bswrl_pkg::MB_BYTES[thr_bit_q]) begin
          thr_q <= thr_q + mcand_q;
        end
        mcand_q   <= {mcand_q[TOTAL_W-2:0], 1'b0};
        thr_bit_q <= thr_bit_q + 1'b1;
        if (thr_bit_q == bswrl_pkg::MB_BIT_W'(bswrl_pkg::MB_W - 1)) begin
          thr_busy_q <= 1'b0;
        end
      end
    end
  end

  // bucket count clamped to 1..MAX_BUCKETS
  always_comb begin
    if (cnt_q == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cnt_q > CNT_W'(bswrl_pkg::MAX_BUCKETS)) begin
      cnt_eff = CNT_W'(bswrl_pkg::MAX_BUCKETS);
    end else begin
      cnt_eff = cnt_q;
    end
  end

  // a word from an older epoch reads as empty
  assign entry_val = (rd_q.epoch == epoch_q) ? rd_q.bytes : '0;
  assign last_eff  = (last_q == '0) ? now_q : last_q;
  assign trial     = {rem_q, quo_q[TIME_W-1]};
  assign head_next = ((CNT_W'(head_q) + 1'b1) >= cnt_eff) ? '0 : (CNT_W'(head_q) + 1'b1);

  assign s_axis_tready_o = (state_q == S_IDLE) && !thr_busy_q;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // sequencer
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    total_d     = total_q;
    last_d      = last_q;
    epoch_d     = epoch_q;
    sweep_d     = sweep_q;
    steps_d     = steps_q;
    div_cnt_d   = div_cnt_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    bytes_d     = bytes_q;
    now_d       = now_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    out_total_d = out_total_q;
    out_hit_d   = out_hit_q;
    mem_we      = 1'b0;
    mem_waddr   = head_q;
    mem_raddr   = head_q;
    mem_wdata   = '{epoch: epoch_q, bytes: '0};

    unique case (state_q) inside
      // clearing pass after reset and when the epoch tag wraps
      S_INIT, S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '{epoch: '0, bytes: '0};
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == '1) begin
          state_d = (state_q == S_INIT) ? S_IDLE : S_ADDRD;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          bytes_d = s_axis_tdata_i[bswrl_pkg::BYTES_W-1:0];
          now_d   = s_axis_tdata_i[bswrl_pkg::BYTES_W +: TIME_W];
          state_d = S_CHECK;
        end
      end
      // seed the time stamp and decide whether any bucket can move
      S_CHECK: begin
        last_d = last_eff;
        if (now_q > last_eff && bsec_q != '0) begin
          quo_d     = now_q - last_eff;
          rem_d     = '0;
          div_cnt_d = '0;
          state_d   = S_DIV;
        end else begin
          state_d = S_ADDRD;
        end
      end
      // restoring divide, one quotient bit a cycle
      S_DIV: begin
        if (trial >= {1'b0, bsec_q}) begin
          rem_d = BSEC_W'(trial - {1'b0, bsec_q});
          quo_d = {quo_q[TIME_W-2:0], 1'b1};
        end else begin
          rem_d = trial[BSEC_W-1:0];
          quo_d = {quo_q[TIME_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == bswrl_pkg::DIV_CNT_W'(TIME_W - 1)) begin
          state_d = S_DIVEND;
        end
      end
      // whole buckets elapsed: step the ring or drop the window
      S_DIVEND: begin
        if (quo_q == '0) begin
          state_d = S_ADDRD;
        end else begin
          last_d = now_q - TIME_W'(rem_q);
          if (quo_q >= TIME_W'(cnt_eff)) begin
            total_d = '0;
            if (epoch_q == '1) begin
              epoch_d = '0;
              sweep_d = '0;
              state_d = S_SWEEP;
            end else begin
              epoch_d = epoch_q + 1'b1;
              state_d = S_ADDRD;
            end
          end else begin
            steps_d = quo_q[CNT_W-1:0];
            state_d = S_SHRD;
          end
        end
      end
      // move the head and fetch the bucket it enters
      S_SHRD: begin
        head_d    = head_next[IDX_W-1:0];
        mem_raddr = head_next[IDX_W-1:0];
        steps_d   = steps_q - 1'b1;
        state_d   = S_SHWR;
      end
      // drop that bucket from the total and clear it
      S_SHWR: begin
        total_d = total_q - entry_val;
        mem_we  = 1'b1;
        state_d = (steps_q == '0) ? S_ADDRD : S_SHRD;
      end
      S_ADDRD: begin
        state_d = S_ADDWR;
      end
      // add the transfer to the head bucket and to the total
      S_ADDWR: begin
        mem_we    = 1'b1;
        mem_wdata = '{epoch: epoch_q, bytes: entry_val + TOTAL_W'(bytes_q)};
        total_d   = total_q + TOTAL_W'(bytes_q);
        state_d   = S_EMIT;
      end
      // load the result register once it is free
      S_EMIT: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d   = 1'b1;
          out_total_d = total_q;
          out_hit_d   = total_q >= thr_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      head_q    <= '0;
      total_q   <= '0;
      last_q    <= '0;
      epoch_q   <= '0;
      sweep_q   <= '0;
      steps_q   <= '0;
      div_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      total_q   <= total_d;
      last_q    <= last_d;
      epoch_q   <= epoch_d;
      sweep_q   <= sweep_d;
      steps_q   <= steps_d;
      div_cnt_q <= div_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    bytes_q     <= bytes_d;
    now_q       <= now_d;
    out_total_q <= out_total_d;
    out_hit_q   <= out_hit_d;
  end

  // bucket store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_total_q;
  assign m_axis_tuser_o  = out_hit_q;

  // no word taken while the threshold is incomplete
  a_thr_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thr_busy_q |-> !s_axis_tready_o)
    else $error("word accepted during threshold build");

  // a stepped head always lands inside the window
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHWR) |-> (CNT_W'(head_q) < cnt_eff))
    else $error("head outside bucket window");

  // once seeded the time stamp never returns to unseeded
  a_seed_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_q != '0) |=> (last_q != '0))
    else $error("last time lost its seed");

  // a result only appears from the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

endmodule
